// ===== hw/rtl/rcd_pkg.sv =====
// ----------------------------------------------------------------------------
// rcd_pkg
// Shared types, codes and name tables for the resource container deframer.
// ----------------------------------------------------------------------------
package rcd_pkg;

	// entry count and size field geometry
	localparam int COUNT_BITS       = 32;
	localparam int COUNT_WIDE       = COUNT_BITS + 4;
	localparam int SIZE_FIELD_BYTES = 4;
	localparam int SIZE_BITS        = 8 * SIZE_FIELD_BYTES;
	localparam int SIZE_IDX_BITS    = (SIZE_FIELD_BYTES > 1) ? $clog2(SIZE_FIELD_BYTES) : 1;

	// known section names
	localparam int SECTION_COUNT       = 7;
	localparam int NAME_MAX            = 12;
	localparam int FIRST_FILES_SECTION = 2;
	localparam logic [2:0] NO_SECTION  = 3'd7;
	localparam logic [3:0] POS_MAX     = 4'd15;

	// separators and digits
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	// names padded to NAME_MAX, first character in the top byte
	localparam logic [8*NAME_MAX-1:0] NAME_TEXT [SECTION_COUNT] = '{
		"COLORS      ",
		"MATERIALS   ",
		"TEXTUREFILES",
		"PALETTEFILES",
		"BACKFILES   ",
		"MASKFILES   ",
		"SOUNDFILES  "
	};
	localparam logic [3:0] NAME_LEN [SECTION_COUNT] = '{
		4'd6, 4'd9, 4'd12, 4'd12, 4'd9, 4'd9, 4'd10
	};

	// parser phase, one-hot
	typedef enum logic [4:0] {
		PH_NAME    = 5'b00001,
		PH_COUNT   = 5'b00010,
		PH_ENAME   = 5'b00100,
		PH_SIZE    = 5'b01000,
		PH_PAYLOAD = 5'b10000
	} phase_t;

	// role of an echoed byte
	typedef enum logic [2:0] {
		ROLE_SECTION_NAME = 3'd0,
		ROLE_SEPARATOR    = 3'd1,
		ROLE_COUNT_DIGIT  = 3'd2,
		ROLE_ENTRY_NAME   = 3'd3,
		ROLE_SIZE_BYTE    = 3'd4,
		ROLE_PAYLOAD      = 3'd5,
		ROLE_END_REPORT   = 3'd6,
		ROLE_IGNORED      = 3'd7
	} role_t;

	// latched error codes
	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_SECTION   = 2'd1,
		ERR_COUNT     = 2'd2,
		ERR_TRUNCATED = 2'd3
	} error_t;

	// name matcher result
	typedef struct packed {
		logic [SECTION_COUNT-1:0] cand_next;
		logic                     hit;
		logic [2:0]               hit_index;
	} match_t;

	// character of a known name at a position, zero past the table
	function automatic logic [7:0] name_char(input int k, input logic [3:0] pos);
		logic [7:0] ch;
		ch = 8'h00;
		for (int i = 0; i < NAME_MAX; i++) begin
			if (pos == 4'(i)) begin
				ch = NAME_TEXT[k][8*(NAME_MAX-1-i) +: 8];
			end
		end
		return ch;
	endfunction

endpackage

// ===== hw/rtl/rcd_name_match.sv =====
// ----------------------------------------------------------------------------
// rcd_name_match
// Narrows the set of candidate section names by one byte and resolves the
// matched section when the name ends.
// ----------------------------------------------------------------------------
module rcd_name_match (
	input  logic [rcd_pkg::SECTION_COUNT-1:0] cand,
	input  logic [3:0]                        pos,
	input  logic [7:0]                        name_byte,
	output rcd_pkg::match_t                   match
);
	import rcd_pkg::*;

	// drop candidates that are too short or differ at this position
	always_comb begin
		for (int k = 0; k < SECTION_COUNT; k++) begin
			match.cand_next[k] = cand[k] && (pos < NAME_LEN[k]) &&
				(name_char(k, pos) == name_byte);
		end
	end

	// lowest candidate whose length equals the bytes seen
	always_comb begin
		match.hit       = 1'b0;
		match.hit_index = NO_SECTION;
		for (int k = SECTION_COUNT - 1; k >= 0; k--) begin
			if (cand[k] && (NAME_LEN[k] == pos)) begin
				match.hit       = 1'b1;
				match.hit_index = 3'(k);
			end
		end
	end

endmodule

// ===== hw/rtl/resource_container_deframer.sv =====
// ----------------------------------------------------------------------------
// resource_container_deframer
// Parses a resource container byte stream into sections and entries and
// echoes each byte with its role, section, entry end mark and error state.
// ----------------------------------------------------------------------------
//  channel   handshake                   payload
//  input     byte_valid / byte_stall     byte_value, end_of_file
//  result    result_valid / result_stall out_byte, role, section_kind,
//                                        last_of_entry, error_code, finished
//
//  One byte per cycle while the result is not stalled: an input register feeds
//  the parse logic, whose result lands in the result register.
//  The parse state is a single set of registers updated once per byte.
//  Reset (arst_n low) returns the parser to the start of a section, no error.
//  A stalled result holds; the input register takes a byte while it is empty
//  or while the result register is free or being drained.
// ----------------------------------------------------------------------------
module resource_container_deframer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] byte_value,
	input  logic       end_of_file,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [7:0] out_byte,
	output logic [2:0] role,
	output logic [2:0] section_kind,
	output logic       last_of_entry,
	output logic [1:0] error_code,
	output logic       finished
);
	import rcd_pkg::*;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eof_s1;

	// parse state
	phase_t                   phase_q, phase_next;
	logic [SECTION_COUNT-1:0] cand_q, cand_next;
	logic [3:0]               pos_q, pos_next;
	logic [2:0]               sect_q, sect_next;
	logic                     has_payload_q, has_payload_next;
	logic [COUNT_BITS-1:0]    entries_q, entries_next;
	logic                     has_digit_q, has_digit_next;
	logic [SIZE_IDX_BITS-1:0] size_idx_q, size_idx_next;
	logic [SIZE_BITS-1:0]     payload_q, payload_next;
	error_t                   error_q, error_next;

	// result register
	logic       res_valid_q;
	logic [7:0] res_byte_q;
	role_t      res_role_q;
	logic [2:0] res_kind_q;
	logic       res_last_q;
	logic       res_fin_q;

	// parse results for the byte in the input stage
	logic [7:0] r_byte;
	role_t      r_role;
	logic [2:0] r_kind;
	logic       r_last;
	logic       r_fin;
	logic       entry_end;
	logic       section_restart;

	logic                  out_free;
	logic                  fire_s1;
	logic [COUNT_WIDE-1:0] count_wide;
	logic [3:0]            digit;
	logic [SIZE_BITS-1:0]  size_asm;
	match_t                match;

	// flow control
	assign out_free   = !res_valid_q || !result_stall;
	assign fire_s1    = valid_s1 && out_free;
	assign byte_stall = valid_s1 && !out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			byte_s1 <= byte_value;
			eof_s1  <= end_of_file;
		end
	end

	rcd_name_match u_match (
		.cand      (cand_q),
		.pos       (pos_q),
		.name_byte (byte_s1),
		.match     (match)
	);

	// count accumulate: entries * 10 + digit, overflow shows in the top bits
	assign digit      = byte_s1[3:0] - CHAR_ZERO[3:0];
	assign count_wide = ({4'b0, entries_q} << 3) + ({4'b0, entries_q} << 1) +
		COUNT_WIDE'(digit);

	// size field assembly, little endian
	always_comb begin
		size_asm = payload_q;
		for (int i = 0; i < SIZE_FIELD_BYTES; i++) begin
			if (size_idx_q == SIZE_IDX_BITS'(i)) begin
				size_asm[8*i +: 8] = byte_s1;
			end
		end
	end

	// parse step
	always_comb begin
		phase_next       = phase_q;
		cand_next        = cand_q;
		pos_next         = pos_q;
		sect_next        = sect_q;
		has_payload_next = has_payload_q;
		entries_next     = entries_q;
		has_digit_next   = has_digit_q;
		size_idx_next    = size_idx_q;
		payload_next     = payload_q;
		error_next       = error_q;
		r_byte           = byte_s1;
		r_role           = ROLE_IGNORED;
		r_kind           = sect_q;
		r_last           = 1'b0;
		r_fin            = 1'b0;
		entry_end        = 1'b0;
		section_restart  = 1'b0;

		if (eof_s1) begin
			r_byte = 8'h00;
			r_role = ROLE_END_REPORT;
			if (error_q == ERR_NONE) begin
				if (phase_q == PH_NAME && pos_q == 4'd0) begin
					r_fin = 1'b1;
				end else begin
					error_next = ERR_TRUNCATED;
				end
			end
		end else if (error_q != ERR_NONE) begin
			r_role = ROLE_IGNORED;
		end else begin
			case (phase_q)
				PH_NAME: begin
					if (byte_s1 == CHAR_SPACE) begin
						r_role = ROLE_SEPARATOR;
						if (match.hit) begin
							sect_next        = match.hit_index;
							has_payload_next = (match.hit_index >= 3'(FIRST_FILES_SECTION));
							phase_next       = PH_COUNT;
							entries_next     = '0;
							has_digit_next   = 1'b0;
							cand_next        = '1;
							pos_next         = 4'd0;
							r_kind           = match.hit_index;
						end else begin
							error_next = ERR_SECTION;
						end
					end else begin
						r_role    = ROLE_SECTION_NAME;
						cand_next = match.cand_next;
						if (pos_q != POS_MAX) begin
							pos_next = pos_q + 4'd1;
						end
					end
				end
				PH_COUNT: begin
					if (byte_s1 == CHAR_NUL) begin
						r_role = ROLE_SEPARATOR;
						if (!has_digit_q) begin
							error_next = ERR_COUNT;
						end else if (entries_q == '0) begin
							section_restart = 1'b1;
						end else begin
							phase_next = PH_ENAME;
						end
					end else begin
						r_role = ROLE_COUNT_DIGIT;
						if (byte_s1 < CHAR_ZERO || byte_s1 > CHAR_NINE) begin
							error_next = ERR_COUNT;
						end else if (count_wide[COUNT_WIDE-1:COUNT_BITS] != 4'd0) begin
							error_next = ERR_COUNT;
						end else begin
							entries_next   = count_wide[COUNT_BITS-1:0];
							has_digit_next = 1'b1;
						end
					end
				end
				PH_ENAME: begin
					if (byte_s1 == CHAR_NUL) begin
						r_role = ROLE_SEPARATOR;
						if (has_payload_q) begin
							phase_next    = PH_SIZE;
							size_idx_next = '0;
							payload_next  = '0;
						end else begin
							r_last    = 1'b1;
							entry_end = 1'b1;
						end
					end else begin
						r_role = ROLE_ENTRY_NAME;
					end
				end
				PH_SIZE: begin
					r_role       = ROLE_SIZE_BYTE;
					payload_next = size_asm;
					if (size_idx_q == SIZE_IDX_BITS'(SIZE_FIELD_BYTES - 1)) begin
						size_idx_next = '0;
						if (size_asm == '0) begin
							r_last    = 1'b1;
							entry_end = 1'b1;
						end else begin
							phase_next = PH_PAYLOAD;
						end
					end else begin
						size_idx_next = size_idx_q + SIZE_IDX_BITS'(1);
					end
				end
				PH_PAYLOAD: begin
					r_role       = ROLE_PAYLOAD;
					payload_next = payload_q - SIZE_BITS'(1);
					if (payload_q == SIZE_BITS'(1)) begin
						r_last    = 1'b1;
						entry_end = 1'b1;
					end
				end
				default: begin
					r_role = ROLE_IGNORED;
				end
			endcase
		end

		// entry complete: next entry or next section
		if (entry_end) begin
			entries_next = entries_q - COUNT_BITS'(1);
			if (entries_q == COUNT_BITS'(1)) begin
				section_restart = 1'b1;
			end else begin
				phase_next = PH_ENAME;
			end
		end

		// back to the start of a section
		if (section_restart) begin
			phase_next       = PH_NAME;
			cand_next        = '1;
			pos_next         = 4'd0;
			sect_next        = NO_SECTION;
			has_payload_next = 1'b0;
		end
	end

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_NAME;
			cand_q        <= '1;
			pos_q         <= 4'd0;
			sect_q        <= NO_SECTION;
			has_payload_q <= 1'b0;
			entries_q     <= '0;
			has_digit_q   <= 1'b0;
			size_idx_q    <= '0;
			payload_q     <= '0;
			error_q       <= ERR_NONE;
		end else if (fire_s1) begin
			phase_q       <= phase_next;
			cand_q        <= cand_next;
			pos_q         <= pos_next;
			sect_q        <= sect_next;
			has_payload_q <= has_payload_next;
			entries_q     <= entries_next;
			has_digit_q   <= has_digit_next;
			size_idx_q    <= size_idx_next;
			payload_q     <= payload_next;
			error_q       <= error_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			res_byte_q <= r_byte;
			res_role_q <= r_role;
			res_kind_q <= r_kind;
			res_last_q <= r_last;
			res_fin_q  <= r_fin;
		end
	end

	// error code follows the latched state of the transfer just parsed
	logic [1:0] res_err_q;
	always_ff @(posedge clk) begin
		if (fire_s1) begin
			res_err_q <= error_next;
		end
	end

	assign result_valid  = res_valid_q;
	assign out_byte      = res_byte_q;
	assign role          = res_role_q;
	assign section_kind  = res_kind_q;
	assign last_of_entry = res_last_q;
	assign error_code    = res_err_q;
	assign finished      = res_fin_q;

endmodule
